### hdl/srld_pkg.sv
package srld_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_LOOP  = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  // Parser phases, one-hot
  typedef enum logic [4:0] {
    PH_OPCODE = 5'b00001,
    PH_SINGLE = 5'b00010,
    PH_PAIR_A = 5'b00100,
    PH_PAIR_B = 5'b01000,
    PH_VARINT = 5'b10000
  } phase_e;

  // Special opcodes
  localparam logic [7:0] OP_WAIT_ONE = 8'hFF;
  localparam logic [7:0] OP_WAIT_VAR = 8'hFE;
  localparam logic [7:0] OP_END      = 8'hFD;
  localparam logic [7:0] OP_PAIR_X   = 8'h1F;
  localparam logic [7:0] OP_PAIR_Y   = 8'h36;
  localparam logic [7:0] OP_PAIR_Z   = 8'h37;

  // Opcode ranges
  localparam logic [7:0] OP_LOW_LAST   = 8'h15;
  localparam logic [7:0] OP_BANK_FIRST = 8'h16;
  localparam logic [7:0] OP_BANK_LAST  = 8'h1E;
  localparam logic [7:0] OP_FIX_FIRST  = 8'h20;
  localparam logic [7:0] OP_FIX_LAST   = 8'h35;
  localparam logic [7:0] OP_GRP_FIRST  = 8'h3C;
  localparam logic [7:0] OP_GRP_LAST   = 8'h3F;
  localparam logic [7:0] OP_HIGH_FIRST = 8'h40;
  localparam logic [7:0] OP_HIGH_LAST  = 8'h8F;

  // Register address bases
  localparam logic [15:0] ADR_DIRECT = 16'h4000;
  localparam logic [15:0] ADR_BANK   = 16'h9000;
  localparam logic [15:0] ADR_FIX    = 16'h5000;
  localparam logic [15:0] ADR_GRP    = 16'h5FF0;

  // Paired command addresses
  localparam logic [15:0] ADR_X_A = 16'h9010;
  localparam logic [15:0] ADR_X_B = 16'h9030;
  localparam logic [15:0] ADR_Y_A = 16'hF800;
  localparam logic [15:0] ADR_Y_B = 16'h4800;
  localparam logic [15:0] ADR_Z_A = 16'hC000;
  localparam logic [15:0] ADR_Z_B = 16'hE000;

  localparam logic [31:0] WAIT_BIAS = 32'd3;

endpackage

### hdl/srld_in_if.sv
interface srld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;

  modport source (output valid, output log_byte, input ready);
  modport sink   (input valid, input log_byte, output ready);
endinterface

### hdl/srld_out_if.sv
interface srld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] reg_address;
  logic [7:0]  reg_data;
  logic [31:0] wait_count;

  modport source (output valid, output kind, output reg_address, output reg_data,
                  output wait_count, input ready);
  modport sink   (input valid, input kind, input reg_address, input reg_data,
                  input wait_count, output ready);
endinterface

### hdl/sound_register_log_decoder.sv
// Channel   Dir  Word
// byte_i    in   log_byte: one opcode or operand byte of the log
// result_o  out  kind, reg_address, reg_data, wait_count
// cfg       in   cfg_we_i / cfg_data_i: loop_enabled
//
// One byte is taken every cycle unless the output stalls; its result, if any,
// appears in the output register on the next cycle. The opcode decode and varint
// shift sit between the parser state and the output register: one byte a cycle.
// Reset clears the parser, the loop flag and the output valid.
// A stalled output holds its word and blocks byte_i until it is taken.
module sound_register_log_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  srld_in_if.sink    byte_i,
  srld_out_if.source result_o
);
  import srld_pkg::*;

  logic        loop_en_q;
  phase_e      phase_q, phase_d;
  logic        playing_q, playing_d;
  logic [15:0] pend_adr_q, pend_adr_d;
  logic [15:0] sec_adr_q, sec_adr_d;
  logic [31:0] varint_q, varint_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [15:0] adr_q, adr_d;
  logic [7:0]  data_q, data_d;
  logic [31:0] wait_q, wait_d;
  logic        res_valid;

  logic        in_ready;
  logic        in_fire;
  logic [7:0]  b;
  logic [3:0]  bank_k;
  logic [1:0]  bank_g;
  logic [1:0]  bank_r;

  assign in_ready     = !out_valid_q || result_o.ready;
  assign byte_i.ready = in_ready;
  assign in_fire      = byte_i.valid && in_ready;
  assign b            = byte_i.log_byte;

  // Banked range: group = k / 3 and remainder, k in 0..8
  assign bank_k = 4'(b - OP_BANK_FIRST);
  always_comb begin
    if (bank_k >= 4'd6) begin
      bank_g = 2'd2;
      bank_r = 2'(bank_k - 4'd6);
    end else if (bank_k >= 4'd3) begin
      bank_g = 2'd1;
      bank_r = 2'(bank_k - 4'd3);
    end else begin
      bank_g = 2'd0;
      bank_r = 2'(bank_k);
    end
  end

  // Parser and result decode
  always_comb begin
    phase_d    = phase_q;
    playing_d  = playing_q;
    pend_adr_d = pend_adr_q;
    sec_adr_d  = sec_adr_q;
    varint_d   = varint_q;
    res_valid  = 1'b0;
    kind_d     = KIND_WRITE;
    adr_d      = '0;
    data_d     = '0;
    wait_d     = '0;
    if (in_fire && playing_q) begin
      case (phase_q)
        PH_SINGLE: begin
          res_valid = 1'b1;
          adr_d     = pend_adr_q;
          data_d    = b;
          phase_d   = PH_OPCODE;
        end
        PH_PAIR_A: begin
          res_valid = 1'b1;
          adr_d     = pend_adr_q;
          data_d    = b;
          phase_d   = PH_PAIR_B;
        end
        PH_PAIR_B: begin
          res_valid = 1'b1;
          adr_d     = sec_adr_q;
          data_d    = b;
          phase_d   = PH_OPCODE;
        end
        PH_VARINT: begin
          varint_d = {varint_q[24:0], b[6:0]};
          if (!b[7]) begin
            res_valid = 1'b1;
            kind_d    = KIND_WAIT;
            wait_d    = varint_d + WAIT_BIAS;
            phase_d   = PH_OPCODE;
          end
        end
        default: begin
          phase_d = PH_OPCODE;
          if (b == OP_WAIT_ONE) begin
            res_valid = 1'b1;
            kind_d    = KIND_WAIT;
            wait_d    = 32'd1;
          end else if (b == OP_WAIT_VAR) begin
            varint_d = '0;
            phase_d  = PH_VARINT;
          end else if (b == OP_END) begin
            res_valid = 1'b1;
            if (loop_en_q) begin
              kind_d = KIND_LOOP;
            end else begin
              kind_d    = KIND_STOP;
              playing_d = 1'b0;
            end
          end else if (b == OP_PAIR_X) begin
            pend_adr_d = ADR_X_A;
            sec_adr_d  = ADR_X_B;
            phase_d    = PH_PAIR_A;
          end else if (b == OP_PAIR_Y) begin
            pend_adr_d = ADR_Y_A;
            sec_adr_d  = ADR_Y_B;
            phase_d    = PH_PAIR_A;
          end else if (b == OP_PAIR_Z) begin
            pend_adr_d = ADR_Z_A;
            sec_adr_d  = ADR_Z_B;
            phase_d    = PH_PAIR_A;
          end else if (b inside {[8'h00:OP_LOW_LAST], [OP_HIGH_FIRST:OP_HIGH_LAST]}) begin
            pend_adr_d = ADR_DIRECT + {8'h00, b};
            phase_d    = PH_SINGLE;
          end else if (b inside {[OP_BANK_FIRST:OP_BANK_LAST]}) begin
            pend_adr_d = ADR_BANK + {2'b00, bank_g, 10'h000, bank_r};
            phase_d    = PH_SINGLE;
          end else if (b inside {[OP_FIX_FIRST:OP_FIX_LAST]}) begin
            pend_adr_d = ADR_FIX + {8'h00, 8'(b - OP_FIX_FIRST)};
            phase_d    = PH_SINGLE;
          end else if (b inside {[OP_GRP_FIRST:OP_GRP_LAST]}) begin
            pend_adr_d = ADR_GRP + {12'h000, b[3:0]};
            phase_d    = PH_SINGLE;
          end
        end
      endcase
    end
  end

  // Parser state and loop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_en_q  <= 1'b0;
      phase_q    <= PH_OPCODE;
      playing_q  <= 1'b1;
      pend_adr_q <= '0;
      sec_adr_q  <= '0;
      varint_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        loop_en_q <= cfg_data_i;
      end
      phase_q    <= phase_d;
      playing_q  <= playing_d;
      pend_adr_q <= pend_adr_d;
      sec_adr_q  <= sec_adr_d;
      varint_q   <= varint_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q <= kind_d;
      adr_q  <= adr_d;
      data_q <= data_d;
      wait_q <= wait_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.kind        = kind_q;
  assign result_o.reg_address = adr_q;
  assign result_o.reg_data    = data_q;
  assign result_o.wait_count  = wait_q;

endmodule

### hdl/srld_checker.sv
module srld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [15:0] reg_address_i,
  input logic [7:0]  reg_data_i,
  input logic [31:0] wait_count_i
);
  import srld_pkg::*;

  // Stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i)
      && $stable(reg_address_i) && $stable(reg_data_i) && $stable(wait_count_i))
    else $error("stalled word changed");

  // A full, stalled output blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // A new word needs an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("word without input byte");

  // Field zeroing per kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_WRITE) ? (wait_count_i == '0)
                                           : (reg_address_i == '0 && reg_data_i == '0))
    else $error("unused fields not zero");

  // Nothing follows the stop marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && kind_i == KIND_STOP |=> !out_valid_i)
    else $error("word after stop");

endmodule

bind sound_register_log_decoder srld_checker u_srld_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .kind_i        (result_o.kind),
  .reg_address_i (result_o.reg_address),
  .reg_data_i    (result_o.reg_data),
  .wait_count_i  (result_o.wait_count)
);
